@@ hdl/clbt_pkg.sv @@
`timescale 1ns / 1ps

package clbt_pkg;

	// default sizes
	localparam int LINE_SIZE_DEF   = 64;
	localparam int KEYWORD_MAX_DEF = 8;

	// fixed field widths
	localparam int CMD_W  = 2;
	localparam int BYTE_W = 8;
	localparam int POS_W  = 6;
	localparam int KW_W   = 64;
	localparam int KLEN_W = 4;
	localparam int VAL_W  = 32;
	localparam int CFG_IDX_W = 1;

	// register reset values
	localparam logic [BYTE_W-1:0] END_CHAR_RST = 8'd10;
	localparam logic [BYTE_W-1:0] SEP_CHAR_RST = 8'd32;

	// characters
	localparam logic [BYTE_W-1:0] CH_NUL   = 8'd0;
	localparam logic [BYTE_W-1:0] CH_TAB   = 8'd9;
	localparam logic [BYTE_W-1:0] CH_LF    = 8'd10;
	localparam logic [BYTE_W-1:0] CH_CR    = 8'd13;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'd32;
	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'd43;
	localparam logic [BYTE_W-1:0] CH_MINUS = 8'd45;
	localparam logic [BYTE_W-1:0] CH_POINT = 8'd46;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'd48;
	localparam logic [BYTE_W-1:0] CH_NINE  = 8'd57;

	// command codes
	localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MATCH = 2'd1;
	localparam logic [CMD_W-1:0] CMD_NUM   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_END_CHAR = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEP_CHAR = 1'd1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_BYTE,
		ST_FIND_CHK,
		ST_FIND_EV,
		ST_MATCH_CHK,
		ST_MATCH_EV,
		ST_NUM_RD,
		ST_NUM_EV,
		ST_RESULT
	} state_t;

	typedef enum logic [1:0] {
		PH_BLANK,
		PH_INT,
		PH_FRAC
	} phase_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic do_byte;
		logic rd_en;
		logic find_step;
		logic match_step;
		logic match_set;
		logic num_step;
		logic num_final;
		logic load_out;
	} ctrl_t;

	// datapath to controller
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic find_hit;
		logic at_end;
		logic find_fail;
		logic len_fail;
		logic match_full;
		logic mismatch;
		logic num_end;
		logic out_free;
	} stat_t;

endpackage

@@ hdl/clbt_req_if.sv @@
`timescale 1ns / 1ps

interface clbt_req_if;
	logic                         valid;
	logic                         ready;
	logic [clbt_pkg::CMD_W-1:0]   cmd;
	logic [clbt_pkg::BYTE_W-1:0]  rx_byte;
	logic [clbt_pkg::POS_W-1:0]   token_position;
	logic [clbt_pkg::KW_W-1:0]    keyword;
	logic [clbt_pkg::KLEN_W-1:0]  keyword_len;

	modport source (output valid, cmd, rx_byte, token_position, keyword, keyword_len,
		input ready);
	modport sink (input valid, cmd, rx_byte, token_position, keyword, keyword_len,
		output ready);
endinterface

@@ hdl/clbt_rsp_if.sv @@
`timescale 1ns / 1ps

interface clbt_rsp_if;
	logic                             valid;
	logic                             ready;
	logic                             line_done;
	logic                             overflow;
	logic                             matched;
	logic                             value_ok;
	logic signed [clbt_pkg::VAL_W-1:0] value;

	modport source (output valid, line_done, overflow, matched, value_ok, value,
		input ready);
	modport sink (input valid, line_done, overflow, matched, value_ok, value,
		output ready);
endinterface

@@ hdl/clbt_ctrl.sv @@
`timescale 1ns / 1ps

module clbt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  clbt_pkg::stat_t   stat,
	output clbt_pkg::ctrl_t   ctrl
);

	clbt_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clbt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		req_ready = 1'b0;
		unique case (state_q)
			clbt_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctrl.latch = 1'b1;
					unique case (stat.cmd)
						clbt_pkg::CMD_BYTE:  state_d = clbt_pkg::ST_BYTE;
						clbt_pkg::CMD_MATCH,
						clbt_pkg::CMD_NUM:   state_d = clbt_pkg::ST_FIND_CHK;
						default:             state_d = clbt_pkg::ST_RESULT;
					endcase
				end
			end
			clbt_pkg::ST_BYTE: begin
				ctrl.do_byte = 1'b1;
				state_d      = clbt_pkg::ST_RESULT;
			end
			// skip tokens until the wanted one starts
			clbt_pkg::ST_FIND_CHK: begin
				if (stat.find_hit) begin
					state_d = (stat.cmd == clbt_pkg::CMD_MATCH) ? clbt_pkg::ST_MATCH_CHK
						: clbt_pkg::ST_NUM_RD;
				end else if (stat.at_end) begin
					ctrl.find_step = 1'b1;
				end else begin
					ctrl.rd_en = 1'b1;
					state_d    = clbt_pkg::ST_FIND_EV;
				end
			end
			clbt_pkg::ST_FIND_EV: begin
				ctrl.find_step = 1'b1;
				state_d = stat.find_fail ? clbt_pkg::ST_RESULT : clbt_pkg::ST_FIND_CHK;
			end
			// keyword compare, one character a pass
			clbt_pkg::ST_MATCH_CHK: begin
				if (stat.len_fail) begin
					state_d = clbt_pkg::ST_RESULT;
				end else if (stat.match_full) begin
					ctrl.match_set = 1'b1;
					state_d        = clbt_pkg::ST_RESULT;
				end else begin
					ctrl.rd_en = 1'b1;
					state_d    = clbt_pkg::ST_MATCH_EV;
				end
			end
			clbt_pkg::ST_MATCH_EV: begin
				if (stat.mismatch) begin
					state_d = clbt_pkg::ST_RESULT;
				end else begin
					ctrl.match_step = 1'b1;
					state_d         = clbt_pkg::ST_MATCH_CHK;
				end
			end
			// number scan
			clbt_pkg::ST_NUM_RD: begin
				if (stat.at_end) begin
					ctrl.num_final = 1'b1;
					state_d        = clbt_pkg::ST_RESULT;
				end else begin
					ctrl.rd_en = 1'b1;
					state_d    = clbt_pkg::ST_NUM_EV;
				end
			end
			clbt_pkg::ST_NUM_EV: begin
				ctrl.num_step = 1'b1;
				if (stat.num_end) begin
					ctrl.num_final = 1'b1;
					state_d        = clbt_pkg::ST_RESULT;
				end else begin
					state_d = clbt_pkg::ST_NUM_RD;
				end
			end
			clbt_pkg::ST_RESULT: begin
				if (stat.out_free) begin
					ctrl.load_out = 1'b1;
					state_d       = clbt_pkg::ST_IDLE;
				end
			end
			default: state_d = clbt_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ hdl/clbt_dp.sv @@
`timescale 1ns / 1ps

module clbt_dp #(
	parameter int LINE_SIZE   = clbt_pkg::LINE_SIZE_DEF,
	parameter int KEYWORD_MAX = clbt_pkg::KEYWORD_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [clbt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [clbt_pkg::BYTE_W-1:0]       cfg_data,
	clbt_req_if.sink                          req,
	clbt_rsp_if.source                        rsp,
	input  clbt_pkg::ctrl_t                   ctrl,
	output clbt_pkg::stat_t                   stat
);

	localparam int DEPTH = LINE_SIZE + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(LINE_SIZE + 1);
	localparam int NW    = $clog2(KEYWORD_MAX + 1);
	localparam int SW    = $clog2(LINE_SIZE + 64 + KEYWORD_MAX + 2) + 1;
	localparam logic [SW-1:0] LS_S = SW'(LINE_SIZE);
	localparam logic [WW-1:0] LS_W = WW'(LINE_SIZE);
	localparam logic [35:0]   MAG_SAT = 36'h080000000;

	// configuration
	logic [clbt_pkg::BYTE_W-1:0] end_char_q, sep_char_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_char_q <= clbt_pkg::END_CHAR_RST;
			sep_char_q <= clbt_pkg::SEP_CHAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				clbt_pkg::REG_END_CHAR: end_char_q <= cfg_data;
				clbt_pkg::REG_SEP_CHAR: sep_char_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// latched query
	logic [clbt_pkg::CMD_W-1:0]  cmd_q;
	logic [clbt_pkg::BYTE_W-1:0] rx_q;
	logic [clbt_pkg::POS_W-1:0]  pos_q;
	logic [clbt_pkg::KW_W-1:0]   kw_q;
	logic [NW-1:0]               n_q;

	// effective keyword length: clamp, then stop at first zero byte
	logic [NW-1:0] n_in;
	logic [clbt_pkg::KLEN_W-1:0] klen_eff;
	logic run;
	always_comb begin
		klen_eff = (req.keyword_len > clbt_pkg::KLEN_W'(KEYWORD_MAX))
			? clbt_pkg::KLEN_W'(KEYWORD_MAX) : req.keyword_len;
		n_in = '0;
		run  = 1'b1;
		for (int j = 0; j < KEYWORD_MAX; j++) begin
			if (run && (clbt_pkg::KLEN_W'(j) < klen_eff) && (req.keyword[8*j +: 8] != 8'd0))
				n_in = NW'(j + 1);
			else
				run = 1'b0;
		end
	end

	// walk state
	logic [SW-1:0]              s_q;
	logic [clbt_pkg::POS_W-1:0] p_q;
	logic [NW-1:0]              i_q;
	logic [WW-1:0]              widx_q;
	clbt_pkg::phase_t           ph_q;
	logic [31:0]                mag_q;
	logic                       neg_q, dig_q;

	// results
	logic res_done_q, res_ovf_q, res_match_q, res_ok_q;
	logic [clbt_pkg::VAL_W-1:0] res_val_q;

	// line store with registered read; valid bits give the all-zero reset
	logic [clbt_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]            vld_q;
	logic [clbt_pkg::BYTE_W-1:0] rd_q;
	logic                        rvld_q;
	logic [SW-1:0]               cur;
	logic [AW-1:0]               rd_addr;
	logic [clbt_pkg::BYTE_W-1:0] c;

	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [clbt_pkg::BYTE_W-1:0] wr_data;

	assign cur     = s_q + SW'(i_q);
	assign rd_addr = cur[AW-1:0];
	assign c       = rvld_q ? rd_q : clbt_pkg::CH_NUL;

	// byte command decode
	logic is_end, is_drop, has_room;
	assign is_end   = (rx_q == end_char_q);
	assign is_drop  = (rx_q == clbt_pkg::CH_CR) || (rx_q == clbt_pkg::CH_NUL)
		|| (rx_q == clbt_pkg::CH_LF);
	assign has_room = (widx_q < LS_W);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = clbt_pkg::CH_NUL;
		if (ctrl.do_byte) begin
			if (is_end) begin
				wr_en   = 1'b1;
				wr_addr = has_room ? AW'(widx_q) : AW'(LINE_SIZE);
			end else if (!is_drop) begin
				wr_en = 1'b1;
				if (has_room) begin
					wr_addr = AW'(widx_q);
					wr_data = rx_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (ctrl.rd_en)
			rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (wr_en)
				vld_q[wr_addr] <= 1'b1;
			if (ctrl.rd_en)
				rvld_q <= vld_q[rd_addr];
		end
	end

	// character classes
	logic c_sep, c_nul, c_blank, c_digit, c_sign, c_point, tok_end;
	assign c_sep   = (c == sep_char_q);
	assign c_nul   = (c == clbt_pkg::CH_NUL);
	assign c_blank = (c == clbt_pkg::CH_SPACE) || ((c >= clbt_pkg::CH_TAB) && (c <= clbt_pkg::CH_CR));
	assign c_digit = (c >= clbt_pkg::CH_ZERO) && (c <= clbt_pkg::CH_NINE);
	assign c_sign  = (c == clbt_pkg::CH_PLUS) || (c == clbt_pkg::CH_MINUS);
	assign c_point = (c == clbt_pkg::CH_POINT);
	assign tok_end = c_sep || c_nul;

	// decimal accumulate with saturation at 2^31
	logic [35:0] mag_mul;
	logic [31:0] mag_nx;
	assign mag_mul = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + 36'(c - clbt_pkg::CH_ZERO);
	assign mag_nx  = (mag_mul > MAG_SAT) ? MAG_SAT[31:0] : mag_mul[31:0];

	// parse step
	logic             stop;
	clbt_pkg::phase_t ph_nx;
	logic             acc, cnt, set_neg;
	always_comb begin
		stop    = 1'b0;
		ph_nx   = ph_q;
		acc     = 1'b0;
		cnt     = 1'b0;
		set_neg = 1'b0;
		case (ph_q)
			clbt_pkg::PH_BLANK: begin
				if (c_blank) begin
					ph_nx = clbt_pkg::PH_BLANK;
				end else if (c_sign) begin
					set_neg = 1'b1;
					ph_nx   = clbt_pkg::PH_INT;
				end else if (c_digit) begin
					acc   = 1'b1;
					ph_nx = clbt_pkg::PH_INT;
				end else if (c_point) begin
					ph_nx = clbt_pkg::PH_FRAC;
				end else begin
					stop = 1'b1;
				end
			end
			clbt_pkg::PH_INT: begin
				if (c_digit)
					acc = 1'b1;
				else if (c_point)
					ph_nx = clbt_pkg::PH_FRAC;
				else
					stop = 1'b1;
			end
			default: begin
				if (c_digit)
					cnt = 1'b1;
				else
					stop = 1'b1;
			end
		endcase
	end

	// final value
	logic [31:0] val_fin;
	always_comb begin
		if (!dig_q)
			val_fin = '0;
		else if (neg_q)
			val_fin = 32'd0 - mag_q;
		else
			val_fin = mag_q[31] ? 32'h7FFFFFFF : mag_q;
	end

	// keyword character at i
	logic [clbt_pkg::KW_W-1:0] kw_sh;
	assign kw_sh = kw_q >> {i_q, 3'b000};

	// walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q <= '0;
		end else if (ctrl.do_byte) begin
			if (is_end)
				widx_q <= '0;
			else if (!is_drop)
				widx_q <= has_room ? widx_q + WW'(1) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			cmd_q <= req.cmd;
			rx_q  <= req.rx_byte;
			pos_q <= req.token_position;
			kw_q  <= req.keyword;
			n_q   <= n_in;
			s_q   <= '0;
			p_q   <= '0;
			i_q   <= '0;
			ph_q  <= clbt_pkg::PH_BLANK;
			mag_q <= '0;
			neg_q <= 1'b0;
			dig_q <= 1'b0;
			res_done_q  <= 1'b0;
			res_ovf_q   <= 1'b0;
			res_match_q <= 1'b0;
			res_ok_q    <= 1'b0;
			res_val_q   <= '0;
		end else begin
			if (ctrl.do_byte) begin
				res_done_q <= is_end;
				res_ovf_q  <= !is_end && !is_drop && !has_room;
			end
			if (ctrl.find_step) begin
				if (stat.at_end || c_sep) begin
					s_q <= s_q + SW'(1);
					p_q <= p_q + clbt_pkg::POS_W'(1);
				end else if (!c_nul) begin
					s_q <= s_q + SW'(1);
				end
			end
			if (ctrl.match_step)
				i_q <= i_q + NW'(1);
			if (ctrl.match_set)
				res_match_q <= 1'b1;
			if (ctrl.num_step && !tok_end) begin
				s_q  <= s_q + SW'(1);
				ph_q <= ph_nx;
				if (set_neg)
					neg_q <= (c == clbt_pkg::CH_MINUS);
				if (acc)
					mag_q <= mag_nx;
				if (acc || cnt)
					dig_q <= 1'b1;
			end
			if (ctrl.num_final) begin
				res_ok_q  <= dig_q;
				res_val_q <= val_fin;
			end
		end
	end

	// output register
	logic out_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (ctrl.load_out) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_out) begin
			rsp.line_done <= res_done_q;
			rsp.overflow  <= res_ovf_q;
			rsp.matched   <= res_match_q;
			rsp.value_ok  <= res_ok_q;
			rsp.value     <= res_val_q;
		end
	end

	assign rsp.valid = out_v_q;

	// status
	always_comb begin
		stat.cmd        = ctrl.latch ? req.cmd : cmd_q;
		stat.find_hit   = (p_q == pos_q);
		stat.at_end     = (cur >= LS_S);
		stat.find_fail  = !c_sep && c_nul;
		stat.len_fail   = ((s_q + SW'(1) + SW'(n_q)) > LS_S);
		stat.match_full = (i_q == n_q);
		stat.mismatch   = (c != kw_sh[7:0]);
		stat.num_end    = tok_end || stop;
		stat.out_free   = !out_v_q || rsp.ready;
	end

endmodule

@@ hdl/command_line_buffer_tokenizer.sv @@
`timescale 1ns / 1ps

// Command line buffer and tokenizer. Received bytes (cmd 0) build a line in a
// LINE_SIZE+1 byte store; a received byte is written in the BYTE state and its
// result loaded in the RESULT state, which waits until the output register is
// free. Keyword match (cmd 1) and number parse (cmd 2) first walk the store to
// the requested token and then scan it; the store has one registered read
// port, so each byte looked at takes a read state and then an evaluation
// state. One word is handled at a time; the next is accepted once the result
// sits in the output register, which holds it until taken. Configuration
// writes go to the end and separator character registers at any idle time.
module command_line_buffer_tokenizer #(
	parameter int LINE_SIZE   = clbt_pkg::LINE_SIZE_DEF,
	parameter int KEYWORD_MAX = clbt_pkg::KEYWORD_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [clbt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [clbt_pkg::BYTE_W-1:0]    cfg_data,
	clbt_req_if.sink                       req,
	clbt_rsp_if.source                     rsp
);

	clbt_pkg::ctrl_t ctrl;
	clbt_pkg::stat_t stat;

	clbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.ctrl      (ctrl)
	);

	clbt_dp #(
		.LINE_SIZE   (LINE_SIZE),
		.KEYWORD_MAX (KEYWORD_MAX)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.rsp       (rsp),
		.ctrl      (ctrl),
		.stat      (stat)
	);

endmodule
